@@ rtl/orle_pkg.sv @@
package orle_pkg;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_END   = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_SEARCH    = 3'd6,
    OP_DUMP      = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_APPENDED  = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_OUT_RANGE = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  localparam int unsigned POS_W = 11;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [10:0] position;
    logic [63:0] record_name;
    logic [7:0]  record_age;
    logic signed [31:0] record_key;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] found_position;
    logic [63:0] out_name;
    logic [7:0]  out_age;
    logic signed [31:0] out_key;
    logic        last_result;
  } out_word_t;

endpackage

@@ rtl/orle_if.sv @@
interface orle_in_if;
  import orle_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface orle_out_if;
  import orle_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/orle_ram.sv @@
module orle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/orle_datapath.sv @@
module orle_datapath #(
  parameter int CAPACITY = 16,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                  clk,
  input  logic                  load,
  input  orle_pkg::in_word_t    in_word,
  input  logic                  rec_we,
  input  logic [AW-1:0]         rec_waddr,
  input  logic                  nx_we,
  input  logic [AW-1:0]         nx_waddr,
  input  logic [AW-1:0]         nx_wdata,
  input  logic                  pv_we,
  input  logic [AW-1:0]         pv_waddr,
  input  logic [AW-1:0]         pv_wdata,
  input  logic [AW-1:0]         raddr,
  output orle_pkg::in_word_t    cur,
  output logic [63:0]           rd_name,
  output logic [7:0]            rd_age,
  output logic [31:0]           rd_key,
  output logic [AW-1:0]         rd_next,
  output logic [AW-1:0]         rd_prev
);
  import orle_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= in_word;
    end
  end

  orle_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_name (.clk, .we(rec_we), .waddr(rec_waddr),
    .wdata(cur.record_name), .raddr, .rdata(rd_name));
  orle_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_age (.clk, .we(rec_we), .waddr(rec_waddr),
    .wdata(cur.record_age), .raddr, .rdata(rd_age));
  orle_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_key (.clk, .we(rec_we), .waddr(rec_waddr),
    .wdata(cur.record_key), .raddr, .rdata(rd_key));
  orle_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_next (.clk, .we(nx_we), .waddr(nx_waddr),
    .wdata(nx_wdata), .raddr, .rdata(rd_next));
  orle_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_prev (.clk, .we(pv_we), .waddr(pv_waddr),
    .wdata(pv_wdata), .raddr, .rdata(rd_prev));
endmodule

@@ rtl/orle_ctrl.sv @@
module orle_ctrl #(
  parameter int CAPACITY = 16,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output orle_pkg::out_word_t   out_data,
  output logic                  load,
  input  orle_pkg::in_word_t    cur,
  output logic                  rec_we,
  output logic [AW-1:0]         rec_waddr,
  output logic                  nx_we,
  output logic [AW-1:0]         nx_waddr,
  output logic [AW-1:0]         nx_wdata,
  output logic                  pv_we,
  output logic [AW-1:0]         pv_waddr,
  output logic [AW-1:0]         pv_wdata,
  output logic [AW-1:0]         raddr,
  input  logic [63:0]           rd_name,
  input  logic [7:0]            rd_age,
  input  logic [31:0]           rd_key,
  input  logic [AW-1:0]         rd_next,
  input  logic [AW-1:0]         rd_prev
);
  import orle_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DEC    = 9'b000000010,
    S_RD     = 9'b000000100,
    S_WALK   = 9'b000001000,
    S_LINK   = 9'b000010000,
    S_DELRD  = 9'b000100000,
    S_DELFIX = 9'b001000000,
    S_OUT    = 9'b010000000,
    S_DUMP   = 9'b100000000
  } state_t;

  state_t      state;
  logic [AW-1:0] head_slot;
  logic [CW-1:0] entry_count;
  logic [CAPACITY-1:0] free_map;
  logic [AW-1:0] alloc_slot;
  logic [AW-1:0] slot;
  logic [AW-1:0] before_s;
  logic [AW-1:0] after_s;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] target;
  logic [2:0] st;
  logic [1:0] phase;
  logic       out_full;
  logic       is_ins;
  logic [POS_W-1:0] cnt_ext;

  assign cnt_ext = POS_W'(entry_count);
  assign in_ready = (state == S_IDLE) && !out_full;
  assign load = in_valid && in_ready;
  assign out_valid = out_full;
  assign is_ins = cur.opcode == OP_INS_FRONT || cur.opcode == OP_INS_END
               || cur.opcode == OP_INS_POS;

  always_comb begin
    alloc_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        alloc_slot = AW'(i);
      end
    end
  end

  always_comb begin
    rec_we = 1'b0; rec_waddr = slot;
    nx_we = 1'b0; nx_waddr = slot; nx_wdata = slot;
    pv_we = 1'b0; pv_waddr = slot; pv_wdata = slot;
    raddr = slot;
    case (state)
      S_LINK: begin
        case (phase)
          2'd0: begin
            rec_we = 1'b1;
            nx_we = 1'b1; pv_we = 1'b1;
            nx_wdata = (entry_count == '0) ? slot : after_s;
            pv_wdata = (entry_count == '0) ? slot : before_s;
          end
          2'd1: begin
            nx_we = 1'b1; nx_waddr = before_s; nx_wdata = slot;
            pv_we = 1'b1; pv_waddr = after_s; pv_wdata = slot;
          end
          default: ;
        endcase
      end
      S_DELFIX: begin
        nx_we = entry_count > CW'(1); nx_waddr = before_s; nx_wdata = after_s;
        pv_we = entry_count > CW'(1); pv_waddr = after_s; pv_wdata = before_s;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head_slot <= '0;
      entry_count <= '0;
      free_map <= '1;
      out_full <= 1'b0;
    end else begin
      if (out_full && out_ready) begin
        out_full <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (load) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          pos <= POS_W'(1);
          st <= ST_OK;
          slot <= head_slot;
          if (is_ins) begin
            if (cur.opcode == OP_INS_POS && cur.position == '0) begin
              out_data <= '{ST_BAD_POS, '0, '0, '0, '0, 1'b1};
              out_full <= 1'b1;
              state <= S_IDLE;
            end else if (entry_count >= CW'(CAPACITY)) begin
              out_data <= '{ST_FULL, '0, '0, '0, '0, 1'b1};
              out_full <= 1'b1;
              state <= S_IDLE;
            end else begin
              if (cur.opcode == OP_INS_FRONT ||
                  (cur.opcode == OP_INS_POS && cur.position == POS_W'(1))) begin
                target <= POS_W'(1);
              end else if (cur.opcode == OP_INS_END || cur.position > cnt_ext) begin
                target <= cnt_ext + POS_W'(1);
                if (cur.opcode == OP_INS_POS) begin
                  st <= ST_APPENDED;
                end
              end else begin
                target <= cur.position;
              end
              state <= S_RD;
            end
          end else if (entry_count == '0) begin
            out_data <= '{ST_EMPTY, '0, '0, '0, '0, 1'b1};
            out_full <= 1'b1;
            state <= S_IDLE;
          end else if (cur.opcode == OP_DEL_POS && cur.position == '0) begin
            out_data <= '{ST_BAD_POS, '0, '0, '0, '0, 1'b1};
            out_full <= 1'b1;
            state <= S_IDLE;
          end else if (cur.opcode == OP_DEL_POS && cur.position > cnt_ext) begin
            out_data <= '{ST_OUT_RANGE, '0, '0, '0, '0, 1'b1};
            out_full <= 1'b1;
            state <= S_IDLE;
          end else begin
            case (cur.opcode)
              OP_DEL_FRONT: target <= POS_W'(1);
              OP_DEL_END:   target <= cnt_ext;
              default:      target <= cur.position;
            endcase
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_WALK;
        end
        S_WALK: begin
          if (is_ins) begin
            if (entry_count == '0) begin
              slot <= alloc_slot; phase <= 2'd0; state <= S_LINK;
            end else if (target == POS_W'(1)) begin
              before_s <= rd_prev; after_s <= slot;
              slot <= alloc_slot; phase <= 2'd0; state <= S_LINK;
            end else if (pos == target - POS_W'(1)) begin
              before_s <= slot; after_s <= rd_next;
              slot <= alloc_slot; phase <= 2'd0; state <= S_LINK;
            end else begin
              slot <= rd_next; pos <= pos + POS_W'(1); state <= S_RD;
            end
          end else if (cur.opcode == OP_SEARCH) begin
            if (rd_key == cur.record_key) begin
              out_data <= '{ST_OK, pos, rd_name, rd_age, rd_key, 1'b1};
              out_full <= 1'b1;
              state <= S_IDLE;
            end else if (pos == cnt_ext) begin
              out_data <= '{ST_NOT_FOUND, '0, '0, '0, '0, 1'b1};
              out_full <= 1'b1;
              state <= S_IDLE;
            end else begin
              slot <= rd_next; pos <= pos + POS_W'(1); state <= S_RD;
            end
          end else if (cur.opcode == OP_DUMP) begin
            out_data <= '{ST_OK, pos, rd_name, rd_age, rd_key, pos == cnt_ext};
            out_full <= 1'b1;
            slot <= rd_next;
            state <= S_DUMP;
          end else if (pos == target) begin
            out_data <= '{ST_OK, pos, rd_name, rd_age, rd_key, 1'b1};
            before_s <= rd_prev; after_s <= rd_next;
            state <= S_DELFIX;
          end else begin
            slot <= rd_next; pos <= pos + POS_W'(1); state <= S_RD;
          end
        end
        S_LINK: begin
          if (phase == 2'd0) begin
            free_map[slot] <= 1'b0;
            if (entry_count == '0 || target == POS_W'(1)) begin
              head_slot <= slot;
            end
            entry_count <= entry_count + CW'(1);
            phase <= 2'd1;
          end else begin
            out_data <= '{st, target, cur.record_name, cur.record_age, cur.record_key, 1'b1};
            out_full <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_DELFIX: begin
          free_map[slot] <= 1'b1;
          entry_count <= entry_count - CW'(1);
          if (entry_count <= CW'(1)) begin
            head_slot <= '0;
          end else if (slot == head_slot) begin
            head_slot <= after_s;
          end
          out_full <= 1'b1;
          state <= S_IDLE;
        end
        S_DUMP: begin
          if (!out_full || out_ready) begin
            if (pos == cnt_ext) begin
              state <= S_IDLE;
            end else begin
              pos <= pos + POS_W'(1);
              state <= S_WALK;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(CAPACITY)) else $error("count overflow");
  a_free: assert property (@(posedge clk) disable iff (rst)
    CW'($countones(free_map)) + entry_count == CW'(CAPACITY)) else $error("free map");
  a_noload: assert property (@(posedge clk) disable iff (rst)
    out_full && !out_ready |-> !load) else $error("accept while result held");
`endif
endmodule

@@ rtl/ordered_record_list_engine_core.sv @@
// channel  | dir | payload
// in_ch    | in  | opcode, position, record_name, record_age, record_key
// out_ch   | out | status, found_position, out_name, out_age, out_key, last_result
// Inserts, deletes and searches walk the links one step at a time through the shared
// RAM read port, each step a read state (S_RD) then a walk state (S_WALK).
// Dump gives one word per entry in list order and waits in S_DUMP while a word is held.
// Synchronous reset clears head, count and free map; the record RAMs are not cleared.
// A held result stalls the engine; no new word is taken until it leaves.
module ordered_record_list_engine_core #(
  parameter int CAPACITY = 16
) (
  input logic       clk,
  input logic       rst,
  orle_in_if.sink   in_ch,
  orle_out_if.source out_ch
);
  import orle_pkg::*;
  localparam int AW = $clog2(CAPACITY);

  logic load, rec_we, nx_we, pv_we;
  logic [AW-1:0] rec_waddr, nx_waddr, nx_wdata, pv_waddr, pv_wdata, raddr;
  in_word_t cur;
  logic [63:0] rd_name;
  logic [7:0]  rd_age;
  logic [31:0] rd_key;
  logic [AW-1:0] rd_next, rd_prev;

  orle_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .load, .cur, .rec_we, .rec_waddr, .nx_we, .nx_waddr, .nx_wdata,
    .pv_we, .pv_waddr, .pv_wdata, .raddr,
    .rd_name, .rd_age, .rd_key, .rd_next, .rd_prev
  );

  orle_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk, .load, .in_word(in_ch.data), .rec_we, .rec_waddr,
    .nx_we, .nx_waddr, .nx_wdata, .pv_we, .pv_waddr, .pv_wdata, .raddr,
    .cur, .rd_name, .rd_age, .rd_key, .rd_next, .rd_prev
  );
endmodule
